FILE: rtl/core/pph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial prefix hash package
// Shared widths, codes, transaction types and elaboration-time helpers for
// the prefix hash table core and its sub-blocks.
// ----------------------------------------------------------------------------
package pph_pkg;

  localparam int unsigned HASH_W  = 30;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned BEGIN_W = 10;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned PROD_W  = 2 * HASH_W;
  localparam int unsigned MU_W    = HASH_W + 1;
  localparam int unsigned REM_W   = 32;

  localparam logic [HASH_W-1:0] HASH_MOD    = 30'd998244353;
  localparam logic [CODE_W-1:0] CODE_OFFSET = 8'd64;

  // Barrett constant floor(2^60 / modulus).
  localparam logic [63:0]     MU_FULL    = (64'd1 << PROD_W) / 64'd998244353;
  localparam logic [MU_W-1:0] BARRETT_MU = MU_FULL[MU_W-1:0];

  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    TAG_TERM,
    TAG_POW,
    TAG_INV,
    TAG_QUERY
  } mul_tag_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_POW,
    ST_A_INV,
    ST_Q_LO,
    ST_Q_MUL,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [CODE_W-1:0]  char_code;
    logic [BEGIN_W-1:0] begin_index;
    logic [LEN_W-1:0]   end_index;
  } cmd_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              error;
    logic [LEN_W-1:0]  string_length;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    mul_tag_e          tag;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              valid;
    mul_tag_e          tag;
    logic [HASH_W-1:0] r;
  } mul_rsp_t;

  // Square-and-multiply, used only to derive constants at elaboration.
  function automatic logic [HASH_W-1:0] pow_mod(input logic [63:0] base_val,
                                                input logic [63:0] exp_val);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] e;
    r = 64'd1;
    b = base_val % 64'(HASH_MOD);
    e = exp_val;
    for (int i = 0; i < 64; i++) begin
      if (e[0]) begin
        r = (r * b) % 64'(HASH_MOD);
      end
      b = (b * b) % 64'(HASH_MOD);
      e = e >> 1;
    end
    return r[HASH_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pph_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pph_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined modular multiplier
// Computes a*b mod 998244353 with Barrett reduction in five register stages.
// A tag travels with each operation so the caller can route the result.
// ----------------------------------------------------------------------------
module pph_modmul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pph_pkg::mul_req_t req_i,
  output pph_pkg::mul_rsp_t      rsp_o
);

  logic [4:0]        vld_q;
  pph_pkg::mul_tag_e tag0_q, tag1_q, tag2_q, tag3_q, tag4_q;

  logic [pph_pkg::HASH_W-1:0] a_q, b_q;
  logic [pph_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [61:0]                quot_full;
  logic [pph_pkg::MU_W-1:0]   quot_d, quot_q;
  logic [pph_pkg::REM_W-1:0]  plo_q;
  logic [pph_pkg::REM_W-1:0]  qm_lo;
  logic [pph_pkg::REM_W-1:0]  rem_d, rem_q;
  logic [pph_pkg::REM_W-1:0]  mod1, mod2;
  logic [pph_pkg::HASH_W-1:0] res_d, res_q;

  assign mod1 = pph_pkg::REM_W'(pph_pkg::HASH_MOD);
  assign mod2 = mod1 << 1;

  assign prod_d    = pph_pkg::PROD_W'(a_q) * pph_pkg::PROD_W'(b_q);
  assign quot_full = 62'(prod_q[pph_pkg::PROD_W-1:pph_pkg::HASH_W-1]) *
                     62'(pph_pkg::BARRETT_MU);
  assign quot_d    = quot_full[61:31];
  // Only the low 32 bits matter: the true remainder stays below three moduli.
  assign qm_lo     = pph_pkg::REM_W'(quot_q) * mod1;
  assign rem_d     = plo_q - qm_lo;

  always_comb begin
    if (rem_q >= mod2) begin
      res_d = pph_pkg::HASH_W'(rem_q - mod2);
    end else if (rem_q >= mod1) begin
      res_d = pph_pkg::HASH_W'(rem_q - mod1);
    end else begin
      res_d = pph_pkg::HASH_W'(rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= req_i.a;
    b_q    <= req_i.b;
    tag0_q <= req_i.tag;
    prod_q <= prod_d;
    tag1_q <= tag0_q;
    quot_q <= quot_d;
    plo_q  <= prod_q[pph_pkg::REM_W-1:0];
    tag2_q <= tag1_q;
    rem_q  <= rem_d;
    tag3_q <= tag2_q;
    res_q  <= res_d;
    tag4_q <= tag3_q;
  end

  assign rsp_o.valid = vld_q[4];
  assign rsp_o.tag   = tag4_q;
  assign rsp_o.r     = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/polynomial_prefix_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial prefix hash table core
// Appends characters, answers substring hash queries and clears the string,
// with prefix hashes and inverse base powers held in two block RAMs.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result is registered and appears in the cycle after the work finishes, on
// rsp_o for exactly one cycle with done_o high, and cannot be held off. Clear,
// unused actions, an append to a full string and an invalid query answer in
// the cycle after acceptance and leave busy low. A query with begin index
// zero needs one RAM read. An append and a query with a nonzero begin index
// go through the five-stage modular multiplier, which an append uses three
// times back to back and a query once after its two prefix reads. The RAM
// contents need no clearing after reset.
module polynomial_prefix_hash_table_core #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned BASE    = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire pph_pkg::cmd_t cmd_i,
  output logic               done_o,
  output pph_pkg::rsp_t      rsp_o
);

  localparam int unsigned AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [pph_pkg::HASH_W-1:0] BaseRed =
    pph_pkg::HASH_W'(64'(BASE) % 64'(pph_pkg::HASH_MOD));
  localparam logic [pph_pkg::HASH_W-1:0] BaseInv =
    pph_pkg::pow_mod(64'(BaseRed), 64'(pph_pkg::HASH_MOD) - 64'd2);

  localparam logic [pph_pkg::HASH_W-1:0] HashOne = 30'd1;

  pph_pkg::state_e state_q, state_d;
  logic [pph_pkg::LEN_W-1:0]  len_q, len_d;
  logic [pph_pkg::HASH_W-1:0] power_q, power_d;
  logic [pph_pkg::HASH_W-1:0] inv_pow_q, inv_pow_d;
  logic [pph_pkg::HASH_W-1:0] last_prefix_q, last_prefix_d;
  logic [pph_pkg::HASH_W-1:0] hi_q, hi_d;
  pph_pkg::cmd_t              cmd_q, cmd_d;
  pph_pkg::rsp_t              rsp_q, rsp_d;
  logic                       done_q, done_d;

  logic                       accept;
  logic                       full;
  logic                       q_valid;
  logic [pph_pkg::HASH_W-1:0] code_ext, char_val;
  logic [pph_pkg::HASH_W-1:0] diff;
  logic [pph_pkg::HASH_W:0]   sum_wide;
  logic [pph_pkg::HASH_W-1:0] sum;

  logic                       pfx_we, pfx_re, inv_we, inv_re;
  logic [AddrW-1:0]           pfx_raddr, inv_raddr, wr_addr;
  logic [pph_pkg::HASH_W-1:0] pfx_rdata, inv_rdata;

  pph_pkg::mul_req_t mul_req;
  pph_pkg::mul_rsp_t mul_rsp;

  assign busy    = (state_q != pph_pkg::ST_IDLE);
  assign accept  = start & ~busy;
  assign full    = 32'(len_q) >= MAX_LEN;
  assign q_valid = ({1'b0, cmd_i.begin_index} < cmd_i.end_index) &&
                   (cmd_i.end_index <= len_q);

  // Character value (code - 64) mod M.
  assign code_ext = pph_pkg::HASH_W'(cmd_i.char_code);
  assign char_val = (cmd_i.char_code >= pph_pkg::CODE_OFFSET) ?
                    code_ext - pph_pkg::HASH_W'(pph_pkg::CODE_OFFSET) :
                    code_ext + pph_pkg::HASH_MOD - pph_pkg::HASH_W'(pph_pkg::CODE_OFFSET);

  assign diff = (hi_q >= pfx_rdata) ? hi_q - pfx_rdata :
                hi_q + pph_pkg::HASH_MOD - pfx_rdata;

  assign sum_wide = {1'b0, last_prefix_q} + {1'b0, mul_rsp.r};
  assign sum      = (sum_wide >= {1'b0, pph_pkg::HASH_MOD}) ?
                    pph_pkg::HASH_W'(sum_wide - {1'b0, pph_pkg::HASH_MOD}) :
                    pph_pkg::HASH_W'(sum_wide);

  assign wr_addr = AddrW'(len_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pph_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i.action)
            pph_pkg::ACT_APPEND: state_d = full ? pph_pkg::ST_IDLE : pph_pkg::ST_A_POW;
            pph_pkg::ACT_QUERY:  state_d = q_valid ? pph_pkg::ST_Q_LO : pph_pkg::ST_IDLE;
            default:             state_d = pph_pkg::ST_IDLE;
          endcase
        end
      end
      pph_pkg::ST_A_POW: state_d = pph_pkg::ST_A_INV;
      pph_pkg::ST_A_INV: state_d = pph_pkg::ST_WAIT;
      pph_pkg::ST_Q_LO: begin
        state_d = (cmd_q.begin_index == '0) ? pph_pkg::ST_IDLE : pph_pkg::ST_Q_MUL;
      end
      pph_pkg::ST_Q_MUL: state_d = pph_pkg::ST_WAIT;
      pph_pkg::ST_WAIT: begin
        if (mul_rsp.valid && (mul_rsp.tag == pph_pkg::TAG_INV ||
                              mul_rsp.tag == pph_pkg::TAG_QUERY)) begin
          state_d = pph_pkg::ST_IDLE;
        end
      end
      default: state_d = pph_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM and multiplier control.
  always_comb begin
    len_d         = len_q;
    power_d       = power_q;
    inv_pow_d     = inv_pow_q;
    last_prefix_d = last_prefix_q;
    hi_d          = hi_q;
    cmd_d         = cmd_q;
    rsp_d         = rsp_q;
    done_d        = 1'b0;
    pfx_we        = 1'b0;
    inv_we        = 1'b0;
    pfx_re        = 1'b0;
    inv_re        = 1'b0;
    pfx_raddr     = '0;
    inv_raddr     = '0;
    mul_req.valid = 1'b0;
    mul_req.tag   = pph_pkg::TAG_TERM;
    mul_req.a     = '0;
    mul_req.b     = '0;

    case (state_q)
      pph_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          case (cmd_i.action)
            pph_pkg::ACT_APPEND: begin
              if (full) begin
                rsp_d  = '{hash_value: '0, error: 1'b1, string_length: len_q};
                done_d = 1'b1;
              end else begin
                mul_req.valid = 1'b1;
                mul_req.tag   = pph_pkg::TAG_TERM;
                mul_req.a     = power_q;
                mul_req.b     = char_val;
              end
            end
            pph_pkg::ACT_QUERY: begin
              if (q_valid) begin
                pfx_re    = 1'b1;
                pfx_raddr = AddrW'(cmd_i.end_index - 1'b1);
                inv_re    = 1'b1;
                inv_raddr = AddrW'(cmd_i.begin_index);
              end else begin
                rsp_d  = '{hash_value: '0, error: 1'b1, string_length: len_q};
                done_d = 1'b1;
              end
            end
            pph_pkg::ACT_CLEAR: begin
              len_d         = '0;
              power_d       = HashOne;
              inv_pow_d     = HashOne;
              last_prefix_d = '0;
              rsp_d         = '{hash_value: '0, error: 1'b0, string_length: '0};
              done_d        = 1'b1;
            end
            default: begin
              rsp_d  = '{hash_value: '0, error: 1'b0, string_length: len_q};
              done_d = 1'b1;
            end
          endcase
        end
      end
      pph_pkg::ST_A_POW: begin
        mul_req.valid = 1'b1;
        mul_req.tag   = pph_pkg::TAG_POW;
        mul_req.a     = power_q;
        mul_req.b     = BaseRed;
      end
      pph_pkg::ST_A_INV: begin
        mul_req.valid = 1'b1;
        mul_req.tag   = pph_pkg::TAG_INV;
        mul_req.a     = inv_pow_q;
        mul_req.b     = BaseInv;
      end
      pph_pkg::ST_Q_LO: begin
        hi_d = pfx_rdata;
        if (cmd_q.begin_index == '0) begin
          rsp_d  = '{hash_value: pfx_rdata, error: 1'b0, string_length: len_q};
          done_d = 1'b1;
        end else begin
          pfx_re    = 1'b1;
          pfx_raddr = AddrW'(cmd_q.begin_index - 1'b1);
        end
      end
      pph_pkg::ST_Q_MUL: begin
        // The inverse power read issued at acceptance is still held.
        mul_req.valid = 1'b1;
        mul_req.tag   = pph_pkg::TAG_QUERY;
        mul_req.a     = diff;
        mul_req.b     = inv_rdata;
      end
      pph_pkg::ST_WAIT: begin
        if (mul_rsp.valid) begin
          case (mul_rsp.tag)
            pph_pkg::TAG_TERM: begin
              pfx_we        = 1'b1;
              inv_we        = 1'b1;
              last_prefix_d = sum;
            end
            pph_pkg::TAG_POW: power_d = mul_rsp.r;
            pph_pkg::TAG_INV: begin
              inv_pow_d = mul_rsp.r;
              len_d     = len_q + 1'b1;
              rsp_d     = '{hash_value: last_prefix_q, error: 1'b0,
                            string_length: len_q + 1'b1};
              done_d    = 1'b1;
            end
            pph_pkg::TAG_QUERY: begin
              rsp_d  = '{hash_value: mul_rsp.r, error: 1'b0, string_length: len_q};
              done_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pph_pkg::ST_IDLE;
      len_q         <= '0;
      power_q       <= HashOne;
      inv_pow_q     <= HashOne;
      last_prefix_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      len_q         <= len_d;
      power_q       <= power_d;
      inv_pow_q     <= inv_pow_d;
      last_prefix_q <= last_prefix_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
  end

  pph_ram #(
    .WIDTH(pph_pkg::HASH_W),
    .DEPTH(MAX_LEN)
  ) u_prefix_ram (
    .clk_i  (clk_i),
    .we_i   (pfx_we),
    .waddr_i(wr_addr),
    .wdata_i(sum),
    .re_i   (pfx_re),
    .raddr_i(pfx_raddr),
    .rdata_o(pfx_rdata)
  );

  pph_ram #(
    .WIDTH(pph_pkg::HASH_W),
    .DEPTH(MAX_LEN)
  ) u_inv_power_ram (
    .clk_i  (clk_i),
    .we_i   (inv_we),
    .waddr_i(wr_addr),
    .wdata_i(inv_pow_q),
    .re_i   (inv_re),
    .raddr_i(inv_raddr),
    .rdata_o(inv_rdata)
  );

  pph_modmul u_modmul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polynomial prefix hash table core testbench
// Drives appends, substring queries, clears and unused actions through the
// start/busy handshake. Every accepted transaction is run through a local
// model of the prefix and inverse power tables. Each strobed result is checked
// field by field against the oldest expected response.
// ----------------------------------------------------------------------------
module tb_top;
  import pph_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned HASH_BASE   = 31;
  localparam int unsigned RAND_ITEMS  = 40;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  cmd_t  cmd_drv = '0;
  logic  done;
  rsp_t  rsp;

  cmd_t  cmd_pending_q[$];
  rsp_t  expected_rsp_q[$];
  int unsigned items_total;
  int unsigned items_taken;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned gen_len;

  // Model state of the hash tables.
  logic [HASH_W-1:0] prefix_mem[TABLE_DEPTH];
  logic [HASH_W-1:0] inv_pow_mem[TABLE_DEPTH];
  logic [LEN_W-1:0]  model_len;
  logic [HASH_W-1:0] model_pow;
  logic [HASH_W-1:0] model_inv_pow;
  logic [HASH_W-1:0] base_inv;

  polynomial_prefix_hash_table_core #(
    .MAX_LEN(TABLE_DEPTH),
    .BASE   (HASH_BASE)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_drv),
    .done_o(done),
    .rsp_o (rsp)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [HASH_W-1:0] mod_mul(logic [HASH_W-1:0] a,
                                                logic [HASH_W-1:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return HASH_W'(p % 64'(HASH_MOD));
  endfunction

  function automatic rsp_t predict_hash_rsp(cmd_t c);
    rsp_t              r;
    logic [HASH_W-1:0] val;
    logic [HASH_W-1:0] prev;
    logic [HASH_W-1:0] hi;
    logic [HASH_W-1:0] lo;
    logic [HASH_W-1:0] diff;
    logic [HASH_W:0]   sum;
    r = '0;
    case (c.action)
      ACT_APPEND: begin
        if (model_len >= TABLE_DEPTH) begin
          r.error = 1'b1;
        end else begin
          // Codes below the offset wrap around the modulus.
          if (c.char_code >= CODE_OFFSET) begin
            val = HASH_W'(c.char_code - CODE_OFFSET);
          end else begin
            val = HASH_MOD + HASH_W'(c.char_code) - HASH_W'(CODE_OFFSET);
          end
          prev = (model_len == 0) ? '0 : prefix_mem[model_len - 1];
          sum = {1'b0, prev} + {1'b0, mod_mul(model_pow, val)};
          if (sum >= {1'b0, HASH_MOD}) begin
            sum = sum - {1'b0, HASH_MOD};
          end
          prefix_mem[model_len] = sum[HASH_W-1:0];
          inv_pow_mem[model_len] = model_inv_pow;
          model_pow = mod_mul(model_pow, HASH_W'(HASH_BASE));
          model_inv_pow = mod_mul(model_inv_pow, base_inv);
          model_len = model_len + 1'b1;
          r.hash_value = sum[HASH_W-1:0];
        end
      end
      ACT_QUERY: begin
        if (LEN_W'(c.begin_index) < c.end_index && c.end_index <= model_len) begin
          hi = prefix_mem[c.end_index - 1];
          if (c.begin_index == 0) begin
            r.hash_value = hi;
          end else begin
            lo = prefix_mem[c.begin_index - 1];
            diff = (hi >= lo) ? hi - lo : hi + HASH_MOD - lo;
            r.hash_value = mod_mul(diff, inv_pow_mem[c.begin_index]);
          end
        end else begin
          r.error = 1'b1;
        end
      end
      ACT_CLEAR: begin
        model_len = '0;
        model_pow = HASH_W'(1);
        model_inv_pow = HASH_W'(1);
      end
      default: begin
      end
    endcase
    r.string_length = model_len;
    return r;
  endfunction

  // Fields that the action does not use get random values.
  task automatic add_item(logic [ACT_W-1:0] act, int code, int b, int e);
    cmd_t c;
    c.action = act;
    c.char_code = (code < 0) ? CODE_W'($urandom) : CODE_W'(code);
    c.begin_index = (b < 0) ? BEGIN_W'($urandom) : BEGIN_W'(b);
    c.end_index = (e < 0) ? LEN_W'($urandom_range(0, TABLE_DEPTH)) : LEN_W'(e);
    cmd_pending_q = {cmd_pending_q, c};
    if (act == ACT_APPEND && gen_len < TABLE_DEPTH) begin
      gen_len++;
    end else if (act == ACT_CLEAR) begin
      gen_len = 0;
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: predicts each accepted transaction and launches the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_drv <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_rsp_q = {expected_rsp_q, predict_hash_rsp(cmd_drv)};
        items_taken <= items_taken + 1;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_pending_q.size() != 0) begin
        start <= 1'b1;
        cmd_drv <= cmd_pending_q.pop_front();
        gap_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: a strobed result is valid for this cycle only.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no transaction outstanding: hash %0d", rsp.hash_value);
        err_count++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp.hash_value !== exp_rsp.hash_value) begin
          $error("hash_value: expected %0d, actual %0d", exp_rsp.hash_value,
                 rsp.hash_value);
          err_count++;
        end
        if (rsp.error !== exp_rsp.error) begin
          $error("error: expected %0d, actual %0d", exp_rsp.error, rsp.error);
          err_count++;
        end
        if (rsp.string_length !== exp_rsp.string_length) begin
          $error("string_length: expected %0d, actual %0d",
                 exp_rsp.string_length, rsp.string_length);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int e;
    logic [HASH_W-1:0] sq;
    logic [31:0]       ex;
    items_taken = 0;
    err_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gen_len = 0;
    model_len = '0;
    model_pow = HASH_W'(1);
    model_inv_pow = HASH_W'(1);

    // Inverse of the base by Fermat: BASE^(M-2).
    base_inv = HASH_W'(1);
    sq = HASH_W'(HASH_BASE);
    ex = 32'(HASH_MOD) - 32'd2;
    while (ex != 0) begin
      if (ex[0]) base_inv = mod_mul(base_inv, sq);
      sq = mod_mul(sq, sq);
      ex = ex >> 1;
    end

    // Directed part: empty string, code extremes, range edges, odd actions.
    add_item(ACT_QUERY, -1, 0, 1);
    add_item(ACT_QUERY, -1, 0, 0);
    add_item(ACT_APPEND, 65, -1, -1);
    add_item(ACT_APPEND, 0, -1, -1);
    add_item(ACT_APPEND, 63, -1, -1);
    add_item(ACT_APPEND, 64, -1, -1);
    add_item(ACT_APPEND, 255, -1, -1);
    add_item(ACT_APPEND, 128, -1, -1);
    add_item(ACT_QUERY, -1, 0, 6);
    add_item(ACT_QUERY, -1, 2, 5);
    add_item(ACT_QUERY, -1, 5, 6);
    add_item(ACT_QUERY, -1, 3, 3);
    add_item(ACT_QUERY, -1, 4, 2);
    add_item(ACT_QUERY, -1, 0, 7);
    add_item(ACT_QUERY, -1, 1023, 1024);
    add_item(ACT_UNUSED, -1, -1, -1);
    add_item(ACT_CLEAR, -1, -1, -1);
    add_item(ACT_QUERY, -1, 0, 1);
    add_item(ACT_APPEND, 90, -1, -1);
    add_item(ACT_QUERY, -1, 0, 1);

    // Fill the table to capacity with a few in-range queries along the way,
    // then push against the full string.
    while (gen_len < TABLE_DEPTH) begin
      add_item(ACT_APPEND, -1, -1, -1);
      if ($urandom_range(0, 99) < 4) begin
        e = $urandom_range(1, gen_len);
        add_item(ACT_QUERY, -1, $urandom_range(0, e - 1), e);
      end
    end
    add_item(ACT_APPEND, -1, -1, -1);
    add_item(ACT_APPEND, 0, -1, -1);
    add_item(ACT_QUERY, -1, 1023, 1024);
    add_item(ACT_QUERY, -1, 0, 1024);
    add_item(ACT_QUERY, -1, 512, 1024);
    add_item(ACT_QUERY, -1, 1, 1023);
    add_item(ACT_QUERY, -1, 1023, 1025);
    add_item(ACT_CLEAR, -1, -1, -1);

    // Random part: mostly appends and in-range queries on the growing string.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_item(ACT_APPEND, -1, -1, -1);
      end else if (r < 96) begin
        if (gen_len != 0 && $urandom_range(0, 99) < 85) begin
          e = $urandom_range(1, gen_len);
          add_item(ACT_QUERY, -1, $urandom_range(0, e - 1), e);
        end else begin
          add_item(ACT_QUERY, -1, -1, -1);
        end
      end else if (r < 99) begin
        add_item(ACT_UNUSED, -1, -1, -1);
      end else begin
        add_item(ACT_CLEAR, -1, -1, -1);
      end
    end
    items_total = cmd_pending_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != items_total || expected_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
